[src/imu_hmt_pkg.sv]
`timescale 1ns / 1ps

package imu_hmt_pkg;

    // sample fields are read as SAMPLE_BITS-bit two's complement
    localparam int SAMPLE_BITS = 16;
    localparam int SEXT_W      = 24;   // widest sample form handled by sext_smp
    localparam int IN_W        = 16;   // width of each sample field on the bus
    localparam int SMP_W       = 17;   // any sample value fits here, signed
    localparam int MS_W        = 16;
    localparam int REG_W       = 15;
    localparam int CFG_IDX_W   = 2;

    localparam int NUM_IN      = 7;
    localparam int TDATA_IN_W  = NUM_IN * IN_W;
    localparam int TUSER_IN_W  = 1;
    localparam int TDATA_OUT_W = 32;

    localparam int HEAD_W      = 25;
    localparam int REL_W       = 26;

    // heading modulus 360 * 65536 = 45 * 2^19
    localparam int MOD_HI      = 45;
    localparam int MOD_LO_BITS = 19;
    localparam logic [HEAD_W-1:0] HEAD_MOD = HEAD_W'(MOD_HI) << MOD_LO_BITS;

    // yaw factor 57.2958 * 65536 / (2048 * 1000) as K / 2^24
    localparam int K_W         = 25;
    localparam logic [K_W-1:0] YAW_K = 25'd30760448;
    localparam int YAW_FRAC    = 24;

    localparam int P1_W        = SMP_W + MS_W;          // |rz| * ms
    localparam int P2_W        = P1_W + K_W;            // |rz| * ms * K
    localparam int STEP_W      = P2_W - YAW_FRAC;
    localparam int X_W         = STEP_W - MOD_LO_BITS;  // part reduced mod 45
    localparam int RECIP_W     = 11;
    localparam logic [RECIP_W-1:0] RECIP = 11'd1456;    // floor(2^16 / 45)
    localparam int RECIP_SH    = 16;
    localparam int Q_W         = X_W + RECIP_W - RECIP_SH;

    localparam int SQ_W        = 2 * SMP_W - 1;         // square of a sample, unsigned
    localparam int SUM_W       = SQ_W + 2;

    localparam int Q_DEPTH     = 2;
    localparam int Q_PTR_W     = $clog2(Q_DEPTH);
    localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] REG_GRAVITY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MOVE_THR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_THR = 2'd2;

    localparam logic [REG_W-1:0] GRAVITY_RST  = 15'd2509;
    localparam logic [REG_W-1:0] MOVE_THR_RST = 15'd512;
    localparam logic [REG_W-1:0] TURN_THR_RST = 15'd1024;

    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_ZERO   = 1'b1;

    typedef struct packed {
        logic [REG_W-1:0] gravity;
        logic [REG_W-1:0] move_thr;
        logic [REG_W-1:0] turn_thr;
    } t_cfg;

    typedef struct packed {
        logic                    action;
        logic signed [SMP_W-1:0] ax;
        logic signed [SMP_W-1:0] ay;
        logic signed [SMP_W-1:0] az;
        logic [SMP_W-1:0]        rz_mag;
        logic                    rz_neg;
        logic [MS_W-1:0]         ms;
        logic                    turn;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_st;

    typedef struct packed {
        logic              busy;
        logic [HEAD_W-1:0] heading;
    } t_bk_st;

    function automatic logic signed [SMP_W-1:0] sext_smp(input logic [IN_W-1:0] v);
        logic [SEXT_W-1:0] m;
        logic [SEXT_W:0]   s;
        m = {{(SEXT_W-IN_W){1'b0}}, v} & ((SEXT_W'(1) << SAMPLE_BITS) - SEXT_W'(1));
        if (m[SAMPLE_BITS-1]) begin
            s = {1'b0, m} - ((SEXT_W+1)'(1) << SAMPLE_BITS);
        end else begin
            s = {1'b0, m};
        end
        return s[SMP_W-1:0];
    endfunction

    function automatic logic [SMP_W-1:0] mag_smp(input logic signed [SMP_W-1:0] v);
        logic [SMP_W-1:0] u;
        u = v;
        return v[SMP_W-1] ? (~u + SMP_W'(1)) : u;
    endfunction

endpackage

[src/imu_heading_motion_tracker_top.sv]
`timescale 1ns / 1ps
// Path: a sample beat is queued, then the back end takes it through its multiply, round,
//   divide, reduce, update and finish steps; a heading zero beat goes straight to finish.
// The back-end sequencer works on one beat at a time and takes no new beat from the queue
//   until it has loaded the last result into the output register.
// The 2-entry queue keeps taking beats while the back end works or the output stalls.
// Reset: synchronous, active low; heading, offset, flags and queue clear, registers
//   return to their defaults.

module imu_heading_motion_tracker_top (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [imu_hmt_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [imu_hmt_pkg::REG_W-1:0]          i_cfg_wdata,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // accel_x, accel_y, accel_z, rate_x, rate_y, rate_z, elapsed_ms
    input  logic [imu_hmt_pkg::TDATA_IN_W-1:0]     s_axis_tdata,
    // action
    input  logic [imu_hmt_pkg::TUSER_IN_W-1:0]     s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // relative_heading, moving, turning, zero pad
    output logic [imu_hmt_pkg::TDATA_OUT_W-1:0]    m_axis_tdata
);
    import imu_hmt_pkg::*;

    t_cfg   r_cfg;
    t_cmd   fr_cmd, q_cmd;
    t_q_st  q_st;
    t_bk_st bk_st;
    logic   push, pop;

    logic signed [REL_W-1:0] rel;
    logic                    moving, turning;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gravity  <= GRAVITY_RST;
            r_cfg.move_thr <= MOVE_THR_RST;
            r_cfg.turn_thr <= TURN_THR_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_GRAVITY:  r_cfg.gravity  <= i_cfg_wdata;
                REG_MOVE_THR: r_cfg.move_thr <= i_cfg_wdata;
                REG_TURN_THR: r_cfg.turn_thr <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    imu_hmt_front u_front (
        .i_valid  (s_axis_tvalid),
        .i_tuser  (s_axis_tuser),
        .i_tdata  (s_axis_tdata),
        .i_cfg    (r_cfg),
        .i_q_full (q_st.full),
        .o_ready  (s_axis_tready),
        .o_push   (push),
        .o_cmd    (fr_cmd)
    );

    imu_hmt_q u_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (fr_cmd),
        .i_pop   (pop),
        .o_cmd   (q_cmd),
        .o_st    (q_st)
    );

    imu_hmt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (q_cmd),
        .i_q_st      (q_st),
        .o_pop       (pop),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_rel       (rel),
        .o_moving    (moving),
        .o_turning   (turning),
        .o_st        (bk_st)
    );

    assign m_axis_tdata = {(TDATA_OUT_W-REL_W-2)'(0), turning, moving, rel};

    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        bk_st.heading < HEAD_MOD)
        else $error("heading accumulator outside [0, 360) degree");

    a_beat_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !q_st.empty)
        else $error("accepted beat not held in queue");

    a_out_from_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(bk_st.busy))
        else $error("result appeared without back-end work");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_st.empty)
        else $error("pop from empty queue");

endmodule

[src/imu_hmt_front.sv]
`timescale 1ns / 1ps

module imu_hmt_front (
    input  logic                                  i_valid,
    input  logic [imu_hmt_pkg::TUSER_IN_W-1:0]    i_tuser,
    input  logic [imu_hmt_pkg::TDATA_IN_W-1:0]    i_tdata,
    input  imu_hmt_pkg::t_cfg                     i_cfg,
    input  logic                                  i_q_full,
    output logic                                  o_ready,
    output logic                                  o_push,
    output imu_hmt_pkg::t_cmd                     o_cmd
);
    import imu_hmt_pkg::*;

    logic signed [SMP_W-1:0] rx, ry, rz;
    logic [SMP_W-1:0]        mx, my, mz;
    logic [SMP_W-1:0]        thr;

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;

    always_comb begin
        rx  = sext_smp(i_tdata[4*IN_W-1:3*IN_W]);
        ry  = sext_smp(i_tdata[5*IN_W-1:4*IN_W]);
        rz  = sext_smp(i_tdata[6*IN_W-1:5*IN_W]);
        mx  = mag_smp(rx);
        my  = mag_smp(ry);
        mz  = mag_smp(rz);
        thr = SMP_W'(i_cfg.turn_thr);

        o_cmd.action = i_tuser[0];
        o_cmd.ax     = sext_smp(i_tdata[IN_W-1:0]);
        o_cmd.ay     = sext_smp(i_tdata[2*IN_W-1:IN_W]);
        o_cmd.az     = sext_smp(i_tdata[3*IN_W-1:2*IN_W]);
        o_cmd.rz_mag = mz;
        o_cmd.rz_neg = rz[SMP_W-1];
        o_cmd.ms     = i_tdata[7*IN_W-1:6*IN_W];
        o_cmd.turn   = (mx > thr) || (my > thr) || (mz > thr);
    end

endmodule

[src/imu_hmt_q.sv]
`timescale 1ns / 1ps

module imu_hmt_q (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  imu_hmt_pkg::t_cmd  i_cmd,
    input  logic               i_pop,
    output imu_hmt_pkg::t_cmd  o_cmd,
    output imu_hmt_pkg::t_q_st o_st
);
    import imu_hmt_pkg::*;

    t_cmd               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr, r_rd;
    logic [Q_CNT_W-1:0] r_cnt;

    function automatic logic [Q_PTR_W-1:0] ptr_inc(input logic [Q_PTR_W-1:0] p);
        return (p == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : p + Q_PTR_W'(1);
    endfunction

    assign o_cmd      = r_mem[r_rd];
    assign o_st.full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_st.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= ptr_inc(r_wr);
            end
            if (i_pop) begin
                r_rd <= ptr_inc(r_rd);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + Q_CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - Q_CNT_W'(1);
            end
        end
    end

endmodule

[src/imu_hmt_back.sv]
`timescale 1ns / 1ps

module imu_hmt_back (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  imu_hmt_pkg::t_cfg                       i_cfg,
    input  imu_hmt_pkg::t_cmd                       i_cmd,
    input  imu_hmt_pkg::t_q_st                      i_q_st,
    output logic                                    o_pop,
    input  logic                                    i_out_ready,
    output logic                                    o_out_valid,
    output logic signed [imu_hmt_pkg::REL_W-1:0]    o_rel,
    output logic                                    o_moving,
    output logic                                    o_turning,
    output imu_hmt_pkg::t_bk_st                     o_st
);
    import imu_hmt_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_MUL1 = 8'b0000_0010,
        S_MUL2 = 8'b0000_0100,
        S_RND  = 8'b0000_1000,
        S_DIV  = 8'b0001_0000,
        S_MOD  = 8'b0010_0000,
        S_UPD  = 8'b0100_0000,
        S_FIN  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    t_cmd              r_cmd;
    logic [P1_W-1:0]   r_p1;
    logic [P2_W-1:0]   r_p2;
    logic [STEP_W-1:0] r_step;
    logic [Q_W-1:0]    r_q;
    logic [HEAD_W-1:0] r_smod;
    logic [SQ_W-1:0]   r_sq_x, r_sq_y, r_sq_z;
    logic [2*REG_W+1:0] r_hi;
    logic [2*REG_W-1:0] r_lo;
    logic              r_lo_en;

    logic [HEAD_W-1:0] r_accum, r_zero;
    logic              r_last_mv, r_last_turn;

    logic                    r_out_valid;
    logic signed [REL_W-1:0] r_out_rel;
    logic                    r_out_mv, r_out_turn;

    logic signed [2*SMP_W-1:0] sq_x, sq_y, sq_z;
    logic [REG_W:0]            g_sum;
    logic [REG_W-1:0]          g_dif;
    logic [P1_W-1:0]           p1;
    logic [P2_W-1:0]           p2;
    logic [SUM_W-1:0]          s_sum;
    logic                      mv;
    logic [P2_W-1:0]           rnd_sum;
    logic [X_W-1:0]            x_hi;
    logic [X_W+RECIP_W-1:0]    q_prod;
    logic [X_W-1:0]            q45, rem, rem_f;
    logic [HEAD_W:0]           h_add, h_add_w, h_sub, h_sub_w;
    logic [HEAD_W-1:0]         h_new;
    logic                      fin_load;

    assign o_pop       = (r_state == S_IDLE) && !i_q_st.empty;
    assign fin_load    = (r_state == S_FIN) && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_rel       = r_out_rel;
    assign o_moving    = r_out_mv;
    assign o_turning   = r_out_turn;
    assign o_st.busy    = (r_state != S_IDLE);
    assign o_st.heading = r_accum;

    always_comb begin
        // squares, threshold bounds and the |rz| * ms product
        sq_x  = r_cmd.ax * r_cmd.ax;
        sq_y  = r_cmd.ay * r_cmd.ay;
        sq_z  = r_cmd.az * r_cmd.az;
        g_sum = {1'b0, i_cfg.gravity} + {1'b0, i_cfg.move_thr};
        g_dif = i_cfg.gravity - i_cfg.move_thr;
        p1    = P1_W'(r_cmd.rz_mag) * P1_W'(r_cmd.ms);

        p2    = P2_W'(r_p1) * P2_W'(YAW_K);
        s_sum = SUM_W'(r_sq_x) + SUM_W'(r_sq_y) + SUM_W'(r_sq_z);
        mv    = (s_sum > SUM_W'(r_hi)) || (r_lo_en && (s_sum < SUM_W'(r_lo)));

        // round half up on the magnitude
        rnd_sum = r_p2 + (P2_W'(1) << (YAW_FRAC - 1));

        // step mod 45*2^19: only the bits from 19 up need reducing mod 45
        x_hi   = r_step[STEP_W-1:MOD_LO_BITS];
        q_prod = (X_W+RECIP_W)'(x_hi) * (X_W+RECIP_W)'(RECIP);
        q45    = X_W'(r_q) * X_W'(MOD_HI);
        rem    = x_hi - q45;                    // in [0, 90)
        rem_f  = (rem >= X_W'(MOD_HI)) ? rem - X_W'(MOD_HI) : rem;

        h_add   = {1'b0, r_accum} + {1'b0, r_smod};
        h_add_w = (h_add >= {1'b0, HEAD_MOD}) ? h_add - {1'b0, HEAD_MOD} : h_add;
        h_sub   = {1'b0, r_accum} - {1'b0, r_smod};
        h_sub_w = h_sub[HEAD_W] ? h_sub + {1'b0, HEAD_MOD} : h_sub;
        h_new   = r_cmd.rz_neg ? h_sub_w[HEAD_W-1:0] : h_add_w[HEAD_W-1:0];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (o_pop) begin
                    n_state = (i_cmd.action == ACT_ZERO) ? S_FIN : S_MUL1;
                end
            end
            S_MUL1: n_state = S_MUL2;
            S_MUL2: n_state = S_RND;
            S_RND:  n_state = S_DIV;
            S_DIV:  n_state = S_MOD;
            S_MOD:  n_state = S_UPD;
            S_UPD:  n_state = S_FIN;
            S_FIN: begin
                if (fin_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath registers, no reset
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
        if (r_state == S_MUL1) begin
            r_p1    <= p1;
            r_sq_x  <= sq_x[SQ_W-1:0];
            r_sq_y  <= sq_y[SQ_W-1:0];
            r_sq_z  <= sq_z[SQ_W-1:0];
            r_hi    <= g_sum * g_sum;
            r_lo    <= g_dif * g_dif;
            r_lo_en <= i_cfg.gravity > i_cfg.move_thr;
        end
        if (r_state == S_MUL2) begin
            r_p2 <= p2;
        end
        if (r_state == S_RND) begin
            r_step <= rnd_sum[P2_W-1:YAW_FRAC];
        end
        if (r_state == S_DIV) begin
            r_q <= q_prod[X_W+RECIP_W-1:RECIP_SH];
        end
        if (r_state == S_MOD) begin
            r_smod <= {rem_f[HEAD_W-MOD_LO_BITS-1:0], r_step[MOD_LO_BITS-1:0]};
        end
        if (fin_load) begin
            r_out_rel  <= {1'b0, r_accum} - {1'b0, r_zero};
            r_out_mv   <= r_last_mv;
            r_out_turn <= r_last_turn;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_accum     <= '0;
            r_zero      <= '0;
            r_last_mv   <= 1'b0;
            r_last_turn <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_pop && (i_cmd.action == ACT_ZERO)) begin
                r_zero <= r_accum;
            end
            if (r_state == S_MUL2) begin
                r_last_mv   <= mv;
                r_last_turn <= r_cmd.turn;
            end
            if ((r_state == S_UPD) && (r_cmd.ms != '0)) begin
                r_accum <= h_new;
            end
            if (fin_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule
